// ----- sv/indexed_max_heap_top_defines.svh -----
// assertion macros for the indexed max-heap
`ifndef INDEXED_MAX_HEAP_TOP_DEFINES_SVH
`define INDEXED_MAX_HEAP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// clocked assertion, off while in reset
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked assertion, also checked during reset
`define IMH_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IMH_ASSERT(lbl, prop, msg)
`define IMH_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- sv/imh_pkg.sv -----
package imh_pkg;

  // default node set size
  localparam int unsigned NumNodesDef = 1024;

  // field widths
  localparam int unsigned NodeW  = 10;
  localparam int unsigned ScoreW = 64;
  localparam int unsigned CountW = 11;

  // cell addressing, sized for the largest node set
  localparam int unsigned LevelW = 5;
  localparam int unsigned RowW   = 16;

  // request codes
  localparam logic [1:0] ReqPush  = 2'd0;
  localparam logic [1:0] ReqPop   = 2'd1;
  localparam logic [1:0] ReqRaise = 2'd2;
  localparam logic [1:0] ReqNop   = 2'd3;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StPresent  = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StDecrease = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NodeW-1:0]  node_index;
    logic [ScoreW-1:0] score_key;
  } in_beat_t;

  typedef struct packed {
    logic              popped_valid;
    logic [NodeW-1:0]  popped_index;
    logic [NodeW-1:0]  top_index;
    logic [CountW-1:0] heap_count;
    logic [1:0]        status;
  } out_beat_t;

  // one heap slot: node and its score
  typedef struct packed {
    logic [NodeW-1:0]  node;
    logic [ScoreW-1:0] score;
  } slot_t;

  // two sibling slots in one row
  typedef slot_t [1:0] pair_t;

  // access to the level cells
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [RowW-1:0]   row;
    logic              rd;
    logic [1:0]        we;
    slot_t             wdata;
  } cell_req_t;

endpackage

// ----- sv/imh_level_cell.sv -----
module imh_level_cell #(
  parameter int unsigned Level = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imh_pkg::cell_req_t req_i,
  input  imh_pkg::pair_t     rd_i,
  output imh_pkg::pair_t     rd_o
);

  localparam int unsigned Rows = (Level < 2) ? 1 : (1 << (Level - 1));
  localparam int unsigned RaW  = (Level < 2) ? 1 : Level - 1;

  imh_pkg::pair_t mem [Rows];
  imh_pkg::pair_t data_q;
  logic           hit_q;
  logic           sel;
  logic [RaW-1:0] row;

  assign sel = (req_i.level == imh_pkg::LevelW'(Level));
  assign row = req_i.row[RaW-1:0];

  // sibling pair storage for this heap level
  always_ff @(posedge clk_i) begin
    if (sel && req_i.we[0]) mem[row][0] <= req_i.wdata;
    if (sel && req_i.we[1]) mem[row][1] <= req_i.wdata;
    if (sel && req_i.rd) data_q <= mem[row];
  end

  // read hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= sel && req_i.rd;
    end
  end

  // read data passes toward the root end of the chain
  assign rd_o = hit_q ? data_q : rd_i;

endmodule

// ----- sv/indexed_max_heap_top.sv -----
// channel | dir | payload                 | beat when
// in      | in  | in_data_i  (in_beat_t)  | in_valid_i && in_ready_o
// out     | out | out_data_o (out_beat_t) | out_valid_o && out_ready_i
//
// one request at a time; the sift loop does one level cell read and one compare-and-write
// per level, a walk that ends at the root or a leaf finishes with a single write, and a pop
// first reads the last slot of the heap and then sifts that slot down from the root
// after reset a clearing pass zeroes scores and positions of all NUM_NODES nodes, no beat taken
// a finished result waits in the output register; a stalled output holds the next request
`include "indexed_max_heap_top_defines.svh"
module indexed_max_heap_top #(
  parameter int unsigned NUM_NODES = imh_pkg::NumNodesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  imh_pkg::in_beat_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imh_pkg::out_beat_t out_data_o
);

  localparam int unsigned PW     = $clog2(NUM_NODES + 1);
  localparam int unsigned NAW    = $clog2(NUM_NODES);
  localparam int unsigned Levels = PW;

  typedef enum logic [3:0] {
    SClear, SIdle, SEval, SPopLast, SUp, SUpEval, SDn, SDnEval, STop, STopEval, SDone
  } state_e;

  function automatic logic [imh_pkg::LevelW-1:0] msb_of(input logic [PW-1:0] n);
    logic [imh_pkg::LevelW-1:0] r;
    r = '0;
    for (int i = 0; i < PW; i++) begin
      if (n[i]) r = imh_pkg::LevelW'(i);
    end
    return r;
  endfunction

  state_e                      state_q, state_d;
  logic [NAW-1:0]              clr_q, clr_d;
  imh_pkg::in_beat_t           req_q, req_d;
  logic [PW-1:0]               count_q, count_d;
  logic [imh_pkg::LevelW-1:0]  lv_q, lv_d;
  logic [PW-1:0]               p_q, p_d;
  logic [imh_pkg::NodeW-1:0]   node_q, node_d;
  logic [imh_pkg::ScoreW-1:0]  key_q, key_d;
  logic                        half_q, half_d;
  logic                        pvalid_q, pvalid_d;
  logic [imh_pkg::NodeW-1:0]   pindex_q, pindex_d;
  logic [imh_pkg::NodeW-1:0]   topidx_q, topidx_d;
  logic [1:0]                  status_q, status_d;
  logic                        out_valid_q, out_valid_d;
  imh_pkg::out_beat_t          out_q, out_d;

  // node memories
  logic [imh_pkg::ScoreW-1:0]  score_mem [NUM_NODES];
  logic [PW-1:0]               pos_mem [NUM_NODES];
  logic [imh_pkg::ScoreW-1:0]  score_rd_q;
  logic [PW-1:0]               pos_rd_q;
  logic                        node_rd;
  logic [NAW-1:0]              node_ra;
  logic                        score_we, pos_we;
  logic [NAW-1:0]              score_wa, pos_wa;
  logic [imh_pkg::ScoreW-1:0]  score_wd;
  logic [PW-1:0]               pos_wd;

  // level cell chain
  imh_pkg::cell_req_t          creq;
  imh_pkg::pair_t              chain [Levels+1];
  imh_pkg::pair_t              crd;

  // derived positions
  logic [PW-1:0]               n_cur;
  logic [PW:0]                 n2, n2p1, cnt_ext;
  logic [PW-1:0]               cnt1;
  logic [imh_pkg::LevelW-1:0]  cnt1_l, pos_l, cnt_l;
  logic [NAW-1:0]              naddr;
  logic                        in_range;
  imh_pkg::slot_t              mine, par, ch, lsl, rsl;
  logic                        pick;

  assign n_cur   = p_q | (PW'(1) << lv_q);
  assign n2      = {n_cur, 1'b0};
  assign n2p1    = {n_cur, 1'b1};
  assign cnt_ext = {1'b0, count_q};
  assign cnt1    = count_q + 1'b1;
  assign cnt1_l  = msb_of(cnt1);
  assign pos_l   = msb_of(pos_rd_q);
  assign cnt_l   = msb_of(count_q);
  assign naddr   = NAW'(req_q.node_index);
  assign in_range = (32'(req_q.node_index) < NUM_NODES);
  assign crd     = chain[0];
  assign mine    = '{node: node_q, score: key_q};
  assign par     = crd[p_q[1]];
  assign lsl     = crd[0];
  assign rsl     = crd[1];
  assign pick    = (n2p1 <= cnt_ext) && (rsl.score > lsl.score);
  assign ch      = pick ? rsl : lsl;

  assign chain[Levels] = '0;

  // one cell per heap level
  for (genvar g = 0; g < Levels; g++) begin : g_cell
    imh_level_cell #(.Level(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (creq),
      .rd_i   (chain[g+1]),
      .rd_o   (chain[g])
    );
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    count_d     = count_q;
    lv_d        = lv_q;
    p_d         = p_q;
    node_d      = node_q;
    key_d       = key_q;
    half_d      = half_q;
    pvalid_d    = pvalid_q;
    pindex_d    = pindex_q;
    topidx_d    = topidx_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    creq        = '0;
    node_rd     = 1'b0;
    node_ra     = naddr;
    score_we    = 1'b0;
    score_wa    = naddr;
    score_wd    = req_q.score_key;
    pos_we      = 1'b0;
    pos_wa      = NAW'(node_q);
    pos_wd      = n_cur;

    unique case (state_q)
      SClear: begin
        score_we = 1'b1;
        score_wa = clr_q;
        score_wd = '0;
        pos_we   = 1'b1;
        pos_wa   = clr_q;
        pos_wd   = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == NAW'(NUM_NODES - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          node_rd  = 1'b1;
          node_ra  = NAW'(in_data_i.node_index);
          creq.rd  = 1'b1;
          status_d = imh_pkg::StOk;
          pvalid_d = 1'b0;
          pindex_d = '0;
          state_d  = SEval;
        end
      end
      SEval: begin
        state_d = STop;
        if (req_q.req_type == imh_pkg::ReqPush) begin
          if (in_range) begin
            if (pos_rd_q != '0) begin
              status_d = imh_pkg::StPresent;
            end else if (32'(count_q) < NUM_NODES) begin
              count_d = cnt1;
              lv_d    = cnt1_l;
              p_d     = cnt1 & ~(PW'(1) << cnt1_l);
              node_d  = req_q.node_index;
              key_d   = score_rd_q;
              state_d = SUp;
            end
          end
        end else if (req_q.req_type == imh_pkg::ReqPop) begin
          if (count_q == '0) begin
            status_d = imh_pkg::StEmpty;
          end else begin
            pvalid_d = 1'b1;
            pindex_d = lsl.node;
            pos_we   = 1'b1;
            pos_wa   = NAW'(lsl.node);
            pos_wd   = '0;
            count_d  = count_q - 1'b1;
            if (count_q != PW'(1)) begin
              creq.level = cnt_l;
              creq.row   = imh_pkg::RowW'((count_q & ~(PW'(1) << cnt_l)) >> 1);
              creq.rd    = 1'b1;
              half_d     = count_q[0];
              state_d    = SPopLast;
            end
          end
        end else if (req_q.req_type == imh_pkg::ReqRaise) begin
          if (in_range) begin
            if (req_q.score_key < score_rd_q) begin
              status_d = imh_pkg::StDecrease;
            end else begin
              score_we = 1'b1;
              if (pos_rd_q != '0) begin
                lv_d    = pos_l;
                p_d     = pos_rd_q & ~(PW'(1) << pos_l);
                node_d  = req_q.node_index;
                key_d   = req_q.score_key;
                state_d = SUp;
              end
            end
          end
        end
      end
      SPopLast: begin
        node_d  = crd[half_q].node;
        key_d   = crd[half_q].score;
        lv_d    = '0;
        p_d     = '0;
        state_d = SDn;
      end
      SUp: begin
        if (lv_q == '0) begin
          creq.level = lv_q;
          creq.row   = imh_pkg::RowW'(p_q >> 1);
          creq.we    = p_q[0] ? 2'b10 : 2'b01;
          creq.wdata = mine;
          pos_we     = 1'b1;
          state_d    = STop;
        end else begin
          creq.level = lv_q - 1'b1;
          creq.row   = imh_pkg::RowW'(p_q >> 2);
          creq.rd    = 1'b1;
          state_d    = SUpEval;
        end
      end
      SUpEval: begin
        creq.level = lv_q;
        creq.row   = imh_pkg::RowW'(p_q >> 1);
        creq.we    = p_q[0] ? 2'b10 : 2'b01;
        pos_we     = 1'b1;
        if (par.score >= key_q) begin
          creq.wdata = mine;
          state_d    = STop;
        end else begin
          creq.wdata = par;
          pos_wa     = NAW'(par.node);
          lv_d       = lv_q - 1'b1;
          p_d        = p_q >> 1;
          state_d    = SUp;
        end
      end
      SDn: begin
        if (n2 > cnt_ext) begin
          creq.level = lv_q;
          creq.row   = imh_pkg::RowW'(p_q >> 1);
          creq.we    = p_q[0] ? 2'b10 : 2'b01;
          creq.wdata = mine;
          pos_we     = 1'b1;
          state_d    = STop;
        end else begin
          creq.level = lv_q + 1'b1;
          creq.row   = imh_pkg::RowW'(p_q);
          creq.rd    = 1'b1;
          state_d    = SDnEval;
        end
      end
      SDnEval: begin
        creq.level = lv_q;
        creq.row   = imh_pkg::RowW'(p_q >> 1);
        creq.we    = p_q[0] ? 2'b10 : 2'b01;
        pos_we     = 1'b1;
        if (ch.score <= key_q) begin
          creq.wdata = mine;
          state_d    = STop;
        end else begin
          creq.wdata = ch;
          pos_wa     = NAW'(ch.node);
          lv_d       = lv_q + 1'b1;
          p_d        = PW'({p_q, pick});
          state_d    = SDn;
        end
      end
      STop: begin
        creq.rd = 1'b1;
        state_d = STopEval;
      end
      STopEval: begin
        topidx_d = (count_q != '0) ? lsl.node : '0;
        state_d  = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.popped_valid = pvalid_q;
          out_d.popped_index = pindex_q;
          out_d.top_index    = topidx_q;
          out_d.heap_count   = imh_pkg::CountW'(count_q);
          out_d.status       = status_q;
          out_valid_d        = 1'b1;
          state_d            = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lv_q     <= lv_d;
    p_q      <= p_d;
    node_q   <= node_d;
    key_q    <= key_d;
    half_q   <= half_d;
    pvalid_q <= pvalid_d;
    pindex_q <= pindex_d;
    topidx_q <= topidx_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // node score and position memories
  always_ff @(posedge clk_i) begin
    if (score_we) score_mem[score_wa] <= score_wd;
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (node_rd) begin
      score_rd_q <= score_mem[node_ra];
      pos_rd_q   <= pos_mem[node_ra];
    end
  end

  `IMH_ASSERT(a_busy_after_beat, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after beat")
  `IMH_ASSERT_NR(a_up_not_root, (state_q == SUpEval) |-> (lv_q != '0), "sift up past root")
  `IMH_ASSERT(a_empty_beat, (out_valid_o && out_data_o.status == imh_pkg::StEmpty) |-> (out_data_o.heap_count == '0 && !out_data_o.popped_valid), "empty pop result")
  `IMH_ASSERT(a_count_step, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1), "count jumped")

endmodule

// ----- sim/tb_indexed_max_heap_top.sv -----
`timescale 1ns / 1ps
module tb_indexed_max_heap_top;

  localparam int unsigned NumNodes = 1024;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  imh_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  imh_pkg::out_beat_t out_data_o;

  indexed_max_heap_top #(.NUM_NODES(NumNodes)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // predicted heap state
  logic [imh_pkg::ScoreW-1:0] pred_score [NumNodes];
  int unsigned pred_pos [NumNodes];
  bit pred_present [NumNodes];
  int unsigned pred_slot [NumNodes];
  int unsigned pred_count;

  imh_pkg::out_beat_t pending_results [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit hold_request = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic void heap_sift_up(input int unsigned node, input int unsigned pos);
    int unsigned ppos;
    int unsigned pnode;
    while (pos > 0) begin
      ppos = (pos - 1) / 2;
      pnode = pred_slot[ppos];
      if (pred_score[pnode] >= pred_score[node]) break;
      pred_slot[pos] = pnode;
      pred_pos[pnode] = pos;
      pos = ppos;
    end
    pred_slot[pos] = node;
    pred_pos[node] = pos;
  endfunction

  function automatic void heap_sift_down(input int unsigned node, input int unsigned pos);
    int unsigned cpos;
    int unsigned cnode;
    forever begin
      cpos = 2 * pos + 1;
      if (cpos >= pred_count) break;
      cnode = pred_slot[cpos];
      if (cpos + 1 < pred_count && pred_score[pred_slot[cpos + 1]] > pred_score[cnode]) begin
        cpos = cpos + 1;
        cnode = pred_slot[cpos];
      end
      if (pred_score[cnode] <= pred_score[node]) break;
      pred_slot[pos] = cnode;
      pred_pos[cnode] = pos;
      pos = cpos;
    end
    pred_slot[pos] = node;
    pred_pos[node] = pos;
  endfunction

  function automatic imh_pkg::out_beat_t heap_apply(input imh_pkg::in_beat_t req);
    imh_pkg::out_beat_t res;
    int unsigned node;
    int unsigned topn;
    int unsigned last;
    res = '0;
    res.status = imh_pkg::StOk;
    node = 32'(req.node_index);
    case (req.req_type)
      imh_pkg::ReqPush: begin
        if (pred_present[node]) begin
          res.status = imh_pkg::StPresent;
        end else if (pred_count < NumNodes) begin
          pred_present[node] = 1'b1;
          pred_count++;
          heap_sift_up(node, pred_count - 1);
        end
      end
      imh_pkg::ReqPop: begin
        if (pred_count == 0) begin
          res.status = imh_pkg::StEmpty;
        end else begin
          topn = pred_slot[0];
          res.popped_valid = 1'b1;
          res.popped_index = imh_pkg::NodeW'(topn);
          pred_present[topn] = 1'b0;
          pred_pos[topn] = 0;
          pred_count--;
          last = pred_slot[pred_count];
          if (last != topn) begin
            pred_slot[0] = last;
            pred_pos[last] = 0;
            heap_sift_down(last, 0);
          end
        end
      end
      imh_pkg::ReqRaise: begin
        if (req.score_key < pred_score[node]) begin
          res.status = imh_pkg::StDecrease;
        end else begin
          pred_score[node] = req.score_key;
          if (pred_present[node]) heap_sift_up(node, pred_pos[node]);
        end
      end
      default: ;
    endcase
    if (pred_count > 0) res.top_index = imh_pkg::NodeW'(pred_slot[0]);
    res.heap_count = imh_pkg::CountW'(pred_count);
    return res;
  endfunction

  // send one beat, valid held until accepted and dropped only for an idle gap
  task automatic send_request(input logic [1:0] kind, input int unsigned node,
                              input logic [imh_pkg::ScoreW-1:0] score);
    imh_pkg::in_beat_t req;
    int unsigned gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.req_type = kind;
    req.node_index = imh_pkg::NodeW'(node);
    req.score_key = score;
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(heap_apply(req));
    @(negedge clk_i);
  endtask

  // receiver: random stalls per beat, long hold on request counted here
  initial begin
    int unsigned gap;
    @(negedge clk_i);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0 || hold_request) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
        if (hold_request) begin
          hold_request = 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    imh_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.popped_valid !== want.popped_valid)
          report_mismatch("popped_valid", 32'(out_data_o.popped_valid),
                          32'(want.popped_valid));
        if (out_data_o.popped_index !== want.popped_index)
          report_mismatch("popped_index", 32'(out_data_o.popped_index),
                          32'(want.popped_index));
        if (out_data_o.top_index !== want.top_index)
          report_mismatch("top_index", 32'(out_data_o.top_index), 32'(want.top_index));
        if (out_data_o.heap_count !== want.heap_count)
          report_mismatch("heap_count", 32'(out_data_o.heap_count), 32'(want.heap_count));
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [imh_pkg::ScoreW-1:0] rand_score();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {32'h0, 24'h0, 8'($urandom)};
      2: return {$urandom, $urandom} | 64'hFFFF_0000_0000_0000;
      default: return 64'h3FF0_0000_0000_0000 + 64'($urandom_range(0, 15));
    endcase
  endfunction

  // extremes and the empty pop, duplicate push, decreasing raise and nop cases
  task automatic test_directed();
    send_request(imh_pkg::ReqPop, 0, '0);
    send_request(imh_pkg::ReqPush, 0, '0);
    send_request(imh_pkg::ReqPush, 0, '0);
    send_request(imh_pkg::ReqPush, NumNodes - 1, '0);
    send_request(imh_pkg::ReqRaise, NumNodes - 1, '1);
    send_request(imh_pkg::ReqRaise, NumNodes - 1, 64'd5);
    send_request(imh_pkg::ReqRaise, NumNodes - 1, '1);
    send_request(imh_pkg::ReqRaise, 32'h155, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(imh_pkg::ReqPush, 32'h155, '0);
    send_request(imh_pkg::ReqRaise, 32'h2AA, 64'h5555_5555_5555_5555);
    send_request(imh_pkg::ReqPush, 32'h2AA, '0);
    send_request(imh_pkg::ReqRaise, 0, 64'h5555_5555_5555_5555);
    send_request(imh_pkg::ReqNop, 32'h3FF, '1);
    send_request(imh_pkg::ReqPop, 0, '0);
    send_request(imh_pkg::ReqPop, 0, '0);
    send_request(imh_pkg::ReqPop, 0, '0);
    send_request(imh_pkg::ReqPop, 0, '0);
    send_request(imh_pkg::ReqPop, 0, '0);
  endtask

  // long output hold while requests keep coming
  task automatic test_backpressure();
    int unsigned k;
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) send_request(imh_pkg::ReqPush, $urandom_range(0, 63), '0);
  endtask

  // random well-formed traffic, biased to a small node pool
  task automatic test_random(input int unsigned n);
    int unsigned k;
    int unsigned r;
    int unsigned node;
    logic [1:0] kind;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      node = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NumNodes - 1)
                                         : $urandom_range(0, 40);
      if (r < 40) kind = imh_pkg::ReqPush;
      else if (r < 65) kind = imh_pkg::ReqPop;
      else if (r < 97) kind = imh_pkg::ReqRaise;
      else kind = imh_pkg::ReqNop;
      if (kind == imh_pkg::ReqRaise && $urandom_range(0, 3) != 0)
        send_request(kind, node, pred_score[node] + 64'($urandom_range(0, 1000)));
      else
        send_request(kind, node, rand_score());
    end
  endtask

  initial begin
    int unsigned waited;
    foreach (pred_score[i]) begin
      pred_score[i] = '0;
      pred_pos[i] = 0;
      pred_present[i] = 1'b0;
      pred_slot[i] = 0;
    end
    pred_count = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(890);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < StallLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
